@@ rtl/rfrw_pkg.sv @@
// Shared types and constants for the reader-writer lock manager.
// No dependencies; imported by the controller, datapath and top level.
package rfrw_pkg;

  localparam int TID_W = 4;
  localparam int AR_W  = 12;
  localparam logic [AR_W-1:0] AR_MAX = {AR_W{1'b1}};

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [2:0] ST_RGRANT  = 3'd0;
  localparam logic [2:0] ST_WGRANT  = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_REL     = 3'd3;
  localparam logic [2:0] ST_NOTHELD = 3'd4;
  localparam logic [2:0] ST_OVF     = 3'd5;
  localparam logic [2:0] ST_BUSY    = 3'd6;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // request transfer
    logic dec;        // decode request, count of requester on read port
    logic u_rd;       // read count of upgrader
    logic u_chk;      // try to grant upgrader
    logic h_rd;       // read queue head entry
    logic h_addr;     // read count of head thread
    logic h_chk;      // try to grant queue head
    logic emit;       // results on the output
    logic emit_step;  // result transfer
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic serve;      // request changed lock state, run the wakeup walk
    logic ub;         // upgrade slot taken
    logic fill_zero;  // queue empty
    logic head_ok;    // head granted this cycle
    logic last;       // current result is the final one
  } sts_t;

endpackage

@@ rtl/rfrw_ctrl.sv @@
// Controller state machine for the lock manager.
// Depends on rfrw_pkg (cmd_t, sts_t).
module rfrw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rfrw_pkg::sts_t sts,
  output rfrw_pkg::cmd_t cmd
);
  import rfrw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_U    = 3'd2;
  localparam logic [2:0] S_U2   = 3'd3;
  localparam logic [2:0] S_H    = 3'd4;
  localparam logic [2:0] S_H2   = 3'd5;
  localparam logic [2:0] S_H3   = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC:  state_next = sts.serve ? S_U : S_EMIT;
      S_U:    state_next = sts.ub ? S_U2 : S_H;
      S_U2:   state_next = S_H;
      S_H:    state_next = sts.fill_zero ? S_EMIT : S_H2;
      S_H2:   state_next = S_H3;
      S_H3:   state_next = sts.head_ok ? S_U : S_EMIT;
      S_EMIT: if (!out_stall && sts.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.dec       = (state == S_DEC);
    cmd.u_rd      = (state == S_U);
    cmd.u_chk     = (state == S_U2);
    cmd.h_rd      = (state == S_H);
    cmd.h_addr    = (state == S_H2);
    cmd.h_chk     = (state == S_H3);
    cmd.emit      = (state == S_EMIT);
    cmd.emit_step = (state == S_EMIT) && !out_stall;
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_stall) |=> (state == S_EMIT))
    else $error("left result state while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_DEC))
    else $error("accepted request not decoded");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_U && !sts.ub) |=> (state == S_H))
    else $error("upgrade check without upgrader");

endmodule

@@ rtl/rfrw_dp.sv @@
// Datapath for the lock manager: counters, read count memory, wait queue,
// grant buffer and result selection. Depends on rfrw_pkg.
module rfrw_dp #(
  parameter int NUM_THREADS = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rfrw_pkg::TID_W-1:0] thread_id,
  input  logic [1:0]                 opcode,
  input  rfrw_pkg::cmd_t             cmd,
  output rfrw_pkg::sts_t             sts,
  output logic [rfrw_pkg::TID_W-1:0] target_thread,
  output logic [2:0]                 status,
  output logic                       last
);
  import rfrw_pkg::*;

  localparam int TW = $clog2(NUM_THREADS);
  localparam int FW = $clog2(NUM_THREADS + 1);
  localparam int GD = NUM_THREADS + 1;
  localparam int GI = $clog2(GD);
  localparam int GW = $clog2(GD + 1);
  localparam int MW = (AR_W > COUNT_WIDTH) ? AR_W : COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  // request
  logic [TID_W-1:0] t_q;
  logic [1:0]       op_q;
  logic [2:0]       own, own_next;

  // lock state
  logic [AR_W-1:0]        ar, ar_next;
  logic [COUNT_WIDTH-1:0] wd, wd_next;
  logic [TID_W-1:0]       wo, wo_next;
  logic                   ub, ub_next;
  logic [TID_W-1:0]       uo, uo_next;
  logic [TW-1:0]          head, head_next, tail, tail_next;
  logic [FW-1:0]          fill, fill_next;
  logic [NUM_THREADS-1:0] waiting, waiting_next;

  // read count memory with valid bits
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_THREADS];
  logic [NUM_THREADS-1:0] cnt_vld;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_rd, cnt_wd;
  logic                   cnt_vq, cnt_we;
  logic [TW-1:0]          cnt_ra, cnt_wa;

  // wait queue
  logic [TID_W:0] fmem [NUM_THREADS];
  logic [TID_W:0] fifo_q;
  logic           push, push_w;

  // grant buffer
  logic [TID_W:0]   gbuf [GD];
  logic [GW-1:0]    gn, eidx;
  logic [TID_W-1:0] lthr;
  logic             lw;
  logic             grant, g_w;
  logic [TID_W-1:0] g_thr;

  logic [TW-1:0]    t_idx, u_idx, h_idx;
  logic             pre_ok, wr_held, h_ok;
  logic [MW-1:0]    ar_x, rd_x;

  assign t_idx  = TW'(t_q);
  assign u_idx  = TW'(uo);
  assign h_idx  = TW'(fifo_q[TID_W-1:0]);
  assign cnt_rd = cnt_vq ? cnt_q : '0;
  assign ar_x   = MW'(ar);
  assign rd_x   = MW'(cnt_rd);

  assign pre_ok = (32'(t_q) < NUM_THREADS) && !waiting[t_idx] &&
                  !(ub && uo == t_q) && (op_q != OP_RSVD);
  assign wr_held = (wd != '0) && (wo == t_q);

  always_comb begin
    cnt_ra = '0;
    if (cmd.accept)      cnt_ra = TW'(thread_id);
    else if (cmd.u_rd)   cnt_ra = u_idx;
    else if (cmd.h_addr) cnt_ra = h_idx;
  end

  always_comb begin
    ar_next = ar; wd_next = wd; wo_next = wo; ub_next = ub; uo_next = uo;
    head_next = head; tail_next = tail; fill_next = fill; waiting_next = waiting;
    own_next = own;
    cnt_we = 1'b0; cnt_wa = t_idx; cnt_wd = cnt_rd;
    push = 1'b0; push_w = 1'b0;
    grant = 1'b0; g_thr = t_q; g_w = 1'b0;
    h_ok = 1'b0;

    if (cmd.dec) begin
      own_next = ST_BUSY;
      if (pre_ok) begin
        case (op_q)
          OP_READ: begin
            if (wr_held) begin
              if (cnt_rd == CMAX) own_next = ST_OVF;
              else begin
                cnt_we = 1'b1; cnt_wd = cnt_rd + 1'b1; own_next = ST_RGRANT;
              end
            end else if (cnt_rd != '0) begin
              if (cnt_rd == CMAX || ar == AR_MAX) own_next = ST_OVF;
              else begin
                cnt_we = 1'b1; cnt_wd = cnt_rd + 1'b1;
                ar_next = ar + 1'b1; own_next = ST_RGRANT;
              end
            end else begin
              push = 1'b1;
            end
          end
          OP_WRITE: begin
            if (wr_held) begin
              if (wd == CMAX) own_next = ST_OVF;
              else begin
                wd_next = wd + 1'b1; own_next = ST_WGRANT;
              end
            end else if (cnt_rd != '0 && !ub) begin
              ub_next = 1'b1; uo_next = t_q; own_next = ST_WAIT;
            end else begin
              if (cnt_rd != '0) begin
                ar_next = (ar_x >= rd_x) ? AR_W'(ar_x - rd_x) : '0;
                cnt_we = 1'b1; cnt_wd = '0;
              end
              push = 1'b1; push_w = 1'b1;
            end
          end
          default: begin
            if (wr_held && cnt_rd != '0) begin
              cnt_we = 1'b1; cnt_wd = cnt_rd - 1'b1; own_next = ST_REL;
            end else if (wr_held) begin
              wd_next = wd - 1'b1;
              if (wd == COUNT_WIDTH'(1)) wo_next = '0;
              own_next = ST_REL;
            end else if (cnt_rd != '0) begin
              cnt_we = 1'b1; cnt_wd = cnt_rd - 1'b1;
              if (ar != '0) ar_next = ar - 1'b1;
              own_next = ST_REL;
            end else begin
              own_next = ST_NOTHELD;
            end
          end
        endcase
        if (push && fill < FW'(NUM_THREADS)) begin
          tail_next = (tail == TW'(NUM_THREADS - 1)) ? '0 : tail + 1'b1;
          fill_next = fill + 1'b1;
          waiting_next[t_idx] = 1'b1;
          own_next = ST_WAIT;
        end
      end
    end

    if (cmd.u_chk) begin
      if (ub && wd == '0 && ar_x <= rd_x) begin
        ar_next = AR_W'(ar_x - rd_x);
        cnt_we = 1'b1; cnt_wa = u_idx; cnt_wd = '0;
        wo_next = uo; wd_next = COUNT_WIDTH'(1); ub_next = 1'b0;
        grant = 1'b1; g_thr = uo; g_w = 1'b1;
      end
    end

    if (cmd.h_chk) begin
      g_thr = fifo_q[TID_W-1:0];
      if (fifo_q[TID_W]) begin
        h_ok = (ar == '0) && (wd == '0);
        if (h_ok) begin
          wo_next = fifo_q[TID_W-1:0]; wd_next = COUNT_WIDTH'(1); g_w = 1'b1;
        end
      end else begin
        h_ok = (wd == '0) && !ub && (ar != AR_MAX) && (cnt_rd != CMAX);
        if (h_ok) begin
          cnt_we = 1'b1; cnt_wa = h_idx; cnt_wd = cnt_rd + 1'b1;
          ar_next = ar + 1'b1;
        end
      end
      if (h_ok) begin
        head_next = (head == TW'(NUM_THREADS - 1)) ? '0 : head + 1'b1;
        fill_next = fill - 1'b1;
        waiting_next[h_idx] = 1'b0;
        grant = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ar <= '0; wd <= '0; wo <= '0; ub <= 1'b0; uo <= '0;
      head <= '0; tail <= '0; fill <= '0; waiting <= '0;
      cnt_vld <= '0; gn <= '0; eidx <= '0;
    end else begin
      ar <= ar_next; wd <= wd_next; wo <= wo_next; ub <= ub_next; uo <= uo_next;
      head <= head_next; tail <= tail_next; fill <= fill_next;
      waiting <= waiting_next;
      if (cnt_we) cnt_vld[cnt_wa] <= 1'b1;
      if (cmd.accept) begin
        gn <= '0; eidx <= '0;
      end else begin
        if (grant) gn <= gn + 1'b1;
        if (cmd.emit_step) eidx <= eidx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_q <= thread_id; op_q <= opcode;
    end
    own <= own_next;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q  <= cnt_mem[cnt_ra];
    cnt_vq <= cnt_vld[cnt_ra];
    if (cmd.dec && push && pre_ok && fill < FW'(NUM_THREADS))
      fmem[tail] <= {push_w, t_q};
    if (cmd.h_rd) fifo_q <= fmem[head];
    if (grant) begin
      gbuf[GI'(gn)] <= {g_w, g_thr};
      lthr <= g_thr; lw <= g_w;
    end
  end

  // requester's own grant, if any, is the last grant and replaces "waiting"
  logic          repl;
  logic [GW-1:0] gsel;
  assign repl = (own == ST_WAIT) && (gn != '0) && (lthr == t_q);
  assign gsel = eidx - 1'b1;

  always_comb begin
    if (eidx == '0) begin
      target_thread = t_q;
      status = repl ? (lw ? ST_WGRANT : ST_RGRANT) : own;
    end else begin
      target_thread = gbuf[GI'(gsel)][TID_W-1:0];
      status = gbuf[GI'(gsel)][TID_W] ? ST_WGRANT : ST_RGRANT;
    end
    last = (eidx == gn - GW'(repl));
  end

  always_comb begin
    sts           = '0;
    sts.serve     = (own_next == ST_RGRANT) || (own_next == ST_WGRANT) ||
                    (own_next == ST_WAIT) || (own_next == ST_REL);
    sts.ub        = ub;
    sts.fill_zero = (fill == '0);
    sts.head_ok   = h_ok;
    sts.last      = last;
  end

  assert property (@(posedge clk) disable iff (rst)
    $countones(waiting) == int'(fill))
    else $error("queue fill disagrees with waiting marks");
  assert property (@(posedge clk) disable iff (rst)
    (wd == '0) |-> (wo == '0))
    else $error("writer owner set without write hold");
  assert property (@(posedge clk) disable iff (rst)
    ub |-> !waiting[u_idx])
    else $error("upgrader also queued");
  assert property (@(posedge clk) disable iff (rst)
    int'(gn) <= GD)
    else $error("grant buffer overrun");

endmodule

@@ rtl/reentrant_fifo_rwlock_manager.sv @@
// Steps: a request is taken and decoded; with the lock state unchanged its
// result follows, else the wakeup walk runs first: an upgrader check (count
// read, grant check; skipped with no upgrader), then a queue head check
// (entry read, count read, grant check; skipped with an empty queue); the walk
// repeats per head grant. Requests go one at a time, after the last result.
// Reset (rst, synchronous): all counts, owners, queue pointers and waiting
// marks clear; queue entries stay unset until written.
module reentrant_fifo_rwlock_manager #(
  parameter int NUM_THREADS = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rfrw_pkg::TID_W-1:0] thread_id,
  input  logic [1:0]                 opcode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rfrw_pkg::TID_W-1:0] target_thread,
  output logic [2:0]                 status,
  output logic                       last
);
  import rfrw_pkg::*;

  // controller steps the request: decode, then upgrader / queue head walk,
  // then one result transfer per cycle from the result state unless stalled
  cmd_t cmd;
  sts_t sts;

  rfrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds lock state, the wait queue and buffered grants
  rfrw_dp #(
    .NUM_THREADS (NUM_THREADS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .thread_id     (thread_id),
    .opcode        (opcode),
    .cmd           (cmd),
    .sts           (sts),
    .target_thread (target_thread),
    .status        (status),
    .last          (last)
  );

endmodule

@@ tb/sv/tb_reentrant_fifo_rwlock_manager.sv @@
// Self-checking testbench for the reentrant FIFO-fair reader-writer lock manager.
// Depends on rfrw_pkg and reentrant_fifo_rwlock_manager; has its own lock predictor.
module tb_reentrant_fifo_rwlock_manager;
  import rfrw_pkg::*;

  localparam int NTHR    = 16;
  localparam int CNT_MAX = 255;
  localparam int ACT_MAX = 4095;
  localparam int LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TID_W-1:0] thread_id = '0;
  logic [1:0] opcode = OP_READ;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TID_W-1:0] target_thread;
  logic [2:0] status;
  logic last;

  reentrant_fifo_rwlock_manager uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .thread_id(thread_id), .opcode(opcode),
    .out_valid(out_valid), .out_stall(out_stall),
    .target_thread(target_thread), .status(status), .last(last)
  );

  typedef struct packed {
    logic [TID_W-1:0] thr;
    logic [2:0]       st;
    logic             lst;
  } lock_result_t;

  // Predictor state: a mirror of the lock tables.
  int unsigned reads_held [NTHR];
  int unsigned reader_total;
  int unsigned wr_depth;
  int unsigned wr_owner;
  bit          upg_busy;
  int unsigned upg_owner;
  logic [4:0]  waitq [NTHR];
  int unsigned q_head, q_tail, q_fill;
  bit          queued [NTHR];

  lock_result_t pending_results[$];
  lock_result_t wake_list[$];
  int errors = 0;
  int unsigned cycle_count = 0;

  // Randomized idling knobs; long_hold forces a receiver backlog.
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall: random bursts while idling is on, or a long hold on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: compare every transfer with the oldest expectation.
  always @(posedge clk) begin
    lock_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result thr=%0d st=%0d last=%0b", target_thread, status, last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (target_thread !== want.thr) begin
          $error("target_thread expected %0d actual %0d", want.thr, target_thread);
          errors++;
        end
        if (status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status);
          errors++;
        end
        if (last !== want.lst) begin
          $error("last expected %0d actual %0d", want.lst, last);
          errors++;
        end
      end
    end
  end

  function automatic void lock_reset();
    for (int i = 0; i < NTHR; i++) begin
      reads_held[i] = 0;
      queued[i] = 1'b0;
      waitq[i] = '0;
    end
    reader_total = 0; wr_depth = 0; wr_owner = 0;
    upg_busy = 1'b0; upg_owner = 0;
    q_head = 0; q_tail = 0; q_fill = 0;
  endfunction

  function automatic bit enqueue_waiter(int unsigned t, bit is_wr);
    if (q_fill >= NTHR) return 1'b0;
    waitq[q_tail] = {is_wr, t[3:0]};
    q_tail = (q_tail + 1) % NTHR;
    q_fill++;
    queued[t] = 1'b1;
    return 1'b1;
  endfunction

  // Wakeup walk: upgrader first, then queue head, until nothing moves.
  function automatic void wake_waiters();
    lock_result_t g;
    int unsigned t;
    forever begin
      if (upg_busy && wr_depth == 0 && reader_total <= reads_held[upg_owner]) begin
        reader_total -= reads_held[upg_owner];
        reads_held[upg_owner] = 0;
        wr_owner = upg_owner; wr_depth = 1; upg_busy = 1'b0;
        g.thr = upg_owner; g.st = ST_WGRANT; g.lst = 1'b0;
        wake_list.push_back(g);
        continue;
      end
      if (q_fill == 0) return;
      t = waitq[q_head][3:0];
      if (waitq[q_head][4]) begin
        if (reader_total != 0 || wr_depth != 0) return;
        wr_owner = t; wr_depth = 1;
        g.st = ST_WGRANT;
      end else begin
        if (wr_depth != 0 || upg_busy || reader_total >= ACT_MAX ||
            reads_held[t] >= CNT_MAX) return;
        reads_held[t]++; reader_total++;
        g.st = ST_RGRANT;
      end
      q_head = (q_head + 1) % NTHR;
      q_fill--;
      queued[t] = 1'b0;
      g.thr = t; g.lst = 1'b0;
      wake_list.push_back(g);
    end
  endfunction

  // Apply one request to the predictor and queue its expected results.
  function automatic void predict_request(logic [3:0] tid, logic [1:0] op);
    int unsigned t = tid;
    logic [2:0] own = ST_BUSY;
    bit is_wr;
    lock_result_t r;
    wake_list.delete();
    if (!queued[t] && !(upg_busy && upg_owner == t) && op != OP_RSVD) begin
      is_wr = wr_depth > 0 && wr_owner == t;
      if (op == OP_READ) begin
        if (is_wr) begin
          if (reads_held[t] >= CNT_MAX) own = ST_OVF;
          else begin reads_held[t]++; own = ST_RGRANT; end
        end else if (reads_held[t] > 0) begin
          if (reads_held[t] >= CNT_MAX || reader_total >= ACT_MAX) own = ST_OVF;
          else begin reads_held[t]++; reader_total++; own = ST_RGRANT; end
        end else if (enqueue_waiter(t, 1'b0)) begin
          own = ST_WAIT;
        end
      end else if (op == OP_WRITE) begin
        if (is_wr) begin
          if (wr_depth >= CNT_MAX) own = ST_OVF;
          else begin wr_depth++; own = ST_WGRANT; end
        end else if (reads_held[t] > 0 && !upg_busy) begin
          upg_busy = 1'b1; upg_owner = t; own = ST_WAIT;
        end else begin
          // second upgrader drops its reads and queues as a writer
          if (reads_held[t] > 0) begin
            reader_total = (reader_total >= reads_held[t]) ? reader_total - reads_held[t] : 0;
            reads_held[t] = 0;
          end
          if (enqueue_waiter(t, 1'b1)) own = ST_WAIT;
        end
      end else begin
        if (is_wr && reads_held[t] > 0) begin
          reads_held[t]--; own = ST_REL;
        end else if (is_wr) begin
          wr_depth--;
          if (wr_depth == 0) wr_owner = 0;
          own = ST_REL;
        end else if (reads_held[t] > 0) begin
          reads_held[t]--;
          if (reader_total > 0) reader_total--;
          own = ST_REL;
        end else begin
          own = ST_NOTHELD;
        end
      end
      if (own != ST_BUSY && own != ST_NOTHELD && own != ST_OVF) wake_waiters();
    end
    // a grant to the requester itself replaces its waiting status
    if (own == ST_WAIT) begin
      for (int k = 0; k < wake_list.size(); k++) begin
        if (wake_list[k].thr == tid) begin
          own = wake_list[k].st;
          wake_list.delete(k);
          break;
        end
      end
    end
    r.thr = tid; r.st = own; r.lst = (wake_list.size() == 0);
    pending_results.push_back(r);
    for (int k = 0; k < wake_list.size(); k++) begin
      r = wake_list[k];
      r.lst = (k == wake_list.size() - 1);
      pending_results.push_back(r);
    end
  endfunction

  // One request transfer, at times with a random gap in front of it; valid stays up
  // after the transfer until the next gap or drain.
  task automatic send_request(logic [3:0] tid, logic [1:0] op);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    thread_id <= tid;
    opcode <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(tid, op);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Directed: every opcode, reentry, nesting, upgrade, busy, not held, unused op.
  task automatic test_directed();
    send_request(4'd3, OP_UNLOCK);   // unlock without hold
    send_request(4'd0, OP_READ);
    send_request(4'd0, OP_READ);     // re-entered read
    send_request(4'd15, OP_READ);
    send_request(4'd15, OP_WRITE);   // becomes upgrader
    send_request(4'd15, OP_READ);    // upgrader is busy
    send_request(4'd0, OP_WRITE);    // second upgrader queues as writer
    send_request(4'd0, OP_READ);     // queued thread is busy
    send_request(4'd7, OP_RSVD);     // unused opcode
    send_request(4'd15, OP_WRITE);   // nested write
    send_request(4'd15, OP_READ);    // writer nests a read
    send_request(4'd5, OP_READ);
    send_request(4'd6, OP_READ);
    send_request(4'd15, OP_UNLOCK);
    send_request(4'd15, OP_UNLOCK);
    send_request(4'd15, OP_UNLOCK);  // wakes writer 0 only
    send_request(4'd0, OP_UNLOCK);   // wakes readers 5 and 6 together
    send_request(4'd5, OP_UNLOCK);
    send_request(4'd6, OP_UNLOCK);
    drain();
  endtask

  // Counter full: re-entered read past the largest count, then an upgrade
  // that drops all those reads at once and a release.
  task automatic test_overflow();
    for (int i = 0; i < CNT_MAX + 1; i++) send_request(4'd9, OP_READ);
    send_request(4'd9, OP_WRITE);
    send_request(4'd9, OP_UNLOCK);
    drain();
  endtask

  // Receiver holds off while requests keep flowing, so the block backs up.
  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++)
          send_request(4'($urandom_range(0, 15)), 2'($urandom_range(0, 2)));
        in_valid <= 1'b0;
        @(posedge clk);
      end
    join
    drain();
  endtask

  // Random traffic biased toward balanced lock and unlock sequences.
  task automatic test_random(int count);
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      if (i == count - 20) idle_on = 1'b0;
      case ($urandom_range(0, 19))
        0: op = OP_RSVD;
        1, 2, 3, 4, 5, 6, 7: op = OP_READ;
        8, 9, 10, 11: op = OP_WRITE;
        default: op = OP_UNLOCK;
      endcase
      send_request(4'($urandom_range(0, 7) == 0 ? $urandom_range(0, 15)
                                                : $urandom_range(0, 5)), op);
      if (i % 20 == 19) drain();
    end
  endtask

  initial begin
    lock_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(60);
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
